### hdl/sct_pkg.sv
// Package for the sparse coordinate table: widths, register indexes,
// status codes and the command/status structs between controller and datapath.
// No dependencies.
package sct_pkg;

  localparam int Capacity = 64;
  localparam int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);

  localparam int CoordW   = 16;
  localparam int SizeW    = 17;
  localparam int ValueW   = 32;
  localparam int StatusW  = 2;
  localparam int EntryW   = 2 * CoordW + ValueW;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgRowCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 1'b1;
  localparam logic [SizeW-1:0]   SizeReset      = 17'h10000;

  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StRange = 2'd1;
  localparam logic [StatusW-1:0] StZero  = 2'd2;
  localparam logic [StatusW-1:0] StFull  = 2'd3;

  typedef struct packed {
    logic               req_load;
    logic               scan_start;
    logic               scan_step;
    logic               mem_wr_hit;
    logic               mem_append;
    logic               res_load;
    logic [StatusW-1:0] res_status;
    logic               res_found;
    logic               res_use_value;
    logic               out_load;
  } sct_cmd_t;

  typedef struct packed {
    logic is_read;
    logic range_bad;
    logic is_zero;
    logic hit;
    logic miss;
    logic full;
    logic out_free;
  } sct_sts_t;

endpackage

### hdl/sparse_coordinate_table.sv
// Sparse coordinate table: bounded list of (row, column, value) triples.
// Top level; instantiates sct_ctrl and sct_datapath, uses sct_pkg.
//
// Input channel (in_valid_i / in_stall_o) carries one request transaction:
// req_type_i 0 writes a coefficient, 1 reads one. Output channel
// (out_valid_o / out_stall_i) returns one result per request: read_value_o,
// found_o and status_o (done, out of range, zero ignored, table full).
// Config port: cfg_we_i writes row count (index 0) or column count (index 1).
// One request is in flight at a time. The entry memory has one read port and
// the scan compares one stored entry per cycle from entry 0: it ends at the
// first hit, and a miss is found once all stored entries are compared. Writes
// that fail the range check or carry zero (sign bit ignored) skip the scan.
// The next request can be taken in the cycle after the result is loaded into
// the output register.
// Reset empties the table (entry memory contents are not cleared) and sets
// both sizes to 65536. While the receiver stalls, the finished result stays
// in the output register; the next request may be accepted and worked on,
// and its result waits until the output register is taken.
module sparse_coordinate_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sct_pkg::SizeW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [sct_pkg::CoordW-1:0]    row_index_i,
  input  logic [sct_pkg::CoordW-1:0]    column_index_i,
  input  logic [sct_pkg::ValueW-1:0]    write_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sct_pkg::ValueW-1:0]    read_value_o,
  output logic                          found_o,
  output logic [sct_pkg::StatusW-1:0]   status_o
);
  import sct_pkg::*;

  sct_cmd_t cmd;
  sct_sts_t sts;

  sct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sct_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .column_index_i (column_index_i),
    .write_value_i  (write_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .read_value_o   (read_value_o),
    .found_o        (found_o),
    .status_o       (status_o)
  );

endmodule

### hdl/sct_datapath.sv
// Datapath of the sparse coordinate table: request and size registers, entry
// memory with linear scan, result and output registers. Uses sct_pkg.
module sct_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sct_pkg::sct_cmd_t             cmd_i,
  output sct_pkg::sct_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [sct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sct_pkg::SizeW-1:0]     cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [sct_pkg::CoordW-1:0]    row_index_i,
  input  logic [sct_pkg::CoordW-1:0]    column_index_i,
  input  logic [sct_pkg::ValueW-1:0]    write_value_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [sct_pkg::ValueW-1:0]    read_value_o,
  output logic                          found_o,
  output logic [sct_pkg::StatusW-1:0]   status_o
);
  import sct_pkg::*;

  logic [SizeW-1:0]   row_count_q, column_count_q;
  logic               req_read_q;
  logic [CoordW-1:0]  req_row_q, req_col_q;
  logic [ValueW-1:0]  req_val_q;

  logic [EntryW-1:0]  mem_q [Capacity];
  logic [EntryW-1:0]  rd_data_q;
  logic [CntW-1:0]    total_q;
  logic [CntW-1:0]    idx_q;
  logic               cmp_vld_q;
  logic [IdxW-1:0]    cmp_idx_q;
  logic               issue;
  logic               rd_en;
  logic               mem_we;
  logic [IdxW-1:0]    wr_addr;

  logic [CoordW-1:0]  rd_row, rd_col;
  logic [ValueW-1:0]  rd_value;

  logic [StatusW-1:0] res_status_q;
  logic               res_found_q;
  logic [ValueW-1:0]  res_value_q;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic               out_found_q;
  logic [ValueW-1:0]  out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= SizeReset;
      column_count_q <= SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRowCount:    row_count_q    <= cfg_wdata_i;
        CfgColumnCount: column_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_read_q <= req_type_i;
      req_row_q  <= row_index_i;
      req_col_q  <= column_index_i;
      req_val_q  <= write_value_i;
    end
  end

  assign rd_row   = rd_data_q[EntryW-1 -: CoordW];
  assign rd_col   = rd_data_q[ValueW +: CoordW];
  assign rd_value = rd_data_q[ValueW-1:0];

  assign issue   = idx_q < total_q;
  assign rd_en   = cmd_i.scan_step && issue;
  assign mem_we  = cmd_i.mem_wr_hit || cmd_i.mem_append;
  assign wr_addr = cmd_i.mem_wr_hit ? cmp_idx_q : total_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= {req_row_q, req_col_q, req_val_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      if (cmd_i.mem_append) begin
        total_q <= total_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= issue;
        if (issue) begin
          idx_q     <= idx_q + 1'b1;
          cmp_idx_q <= idx_q[IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_found;
      res_value_q  <= cmd_i.res_use_value ? rd_value : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_value_q  <= res_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.is_read   = req_read_q;
    sts_o.range_bad = ({1'b0, req_row_q} >= row_count_q) ||
                      ({1'b0, req_col_q} >= column_count_q);
    sts_o.is_zero   = req_val_q[ValueW-2:0] == '0;
    sts_o.hit       = cmp_vld_q && (rd_row == req_row_q) && (rd_col == req_col_q);
    sts_o.miss      = !cmp_vld_q && (idx_q == total_q);
    sts_o.full      = total_q == CntW'(Capacity);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign found_o      = out_found_q;
  assign status_o     = out_status_q;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_append_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_append |-> total_q < CntW'(Capacity))
    else $error("append to a full table");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_append |=> total_q == $past(total_q) + 1'b1)
    else $error("entry count not advanced by append");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.mem_wr_hit && cmd_i.mem_append))
    else $error("overwrite and append in one cycle");
`endif

endmodule

### hdl/sct_ctrl.sv
// Controller of the sparse coordinate table: accepts a request, runs the
// check and the scan, and hands the result to the output register. Uses sct_pkg.
module sct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sct_pkg::sct_sts_t sts_i,
  output sct_pkg::sct_cmd_t cmd_o
);
  import sct_pkg::*;

  localparam logic [1:0] Idle   = 2'd0;
  localparam logic [1:0] Check  = 2'd1;
  localparam logic [1:0] Search = 2'd2;
  localparam logic [1:0] Finish = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != Idle;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = Check;
        end
      end
      Check: begin
        if (!sts_i.is_read && sts_i.range_bad) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = StRange;
          state_d          = Finish;
        end else if (!sts_i.is_read && sts_i.is_zero) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = StZero;
          state_d          = Finish;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = Search;
        end
      end
      Search: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          cmd_o.res_load      = 1'b1;
          cmd_o.res_status    = StDone;
          cmd_o.res_found     = 1'b1;
          cmd_o.res_use_value = sts_i.is_read;
          cmd_o.mem_wr_hit    = !sts_i.is_read;
          state_d             = Finish;
        end else if (sts_i.miss) begin
          cmd_o.res_load = 1'b1;
          if (sts_i.is_read) begin
            cmd_o.res_status = StDone;
          end else if (sts_i.full) begin
            cmd_o.res_status = StFull;
          end else begin
            cmd_o.res_status = StDone;
            cmd_o.mem_append = 1'b1;
          end
          state_d = Finish;
        end
      end
      Finish: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

endmodule

### verif/sct_tb_pkg.sv
// Request codes shared by the sparse coordinate table testbench and checker.
// No dependencies.
package sct_tb_pkg;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqRead  = 1'b1;

endpackage

### verif/sct_checker.sv
// Checker for the sparse coordinate table: tracks sizes and table contents,
// predicts one result per request transaction and compares each result in order.
// Depends on sct_pkg and sct_tb_pkg.
module sct_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sct_pkg::SizeW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          req_type_i,
  input  logic [sct_pkg::CoordW-1:0]    row_index_i,
  input  logic [sct_pkg::CoordW-1:0]    column_index_i,
  input  logic [sct_pkg::ValueW-1:0]    write_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [sct_pkg::ValueW-1:0]    read_value_i,
  input  logic                          found_i,
  input  logic [sct_pkg::StatusW-1:0]   status_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  import sct_pkg::*;
  import sct_tb_pkg::*;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic               found;
    logic [StatusW-1:0] status;
  } coef_result_t;

  logic [CoordW-1:0] row_tab [Capacity];
  logic [CoordW-1:0] col_tab [Capacity];
  logic [ValueW-1:0] val_tab [Capacity];
  int                used_entries;
  logic [SizeW-1:0]  row_limit;
  logic [SizeW-1:0]  column_limit;
  coef_result_t      expected_results [$];
  int                mismatches;

  // Linear search from entry 0, then apply the request to the table copy.
  function automatic coef_result_t resolve_request(logic kind, logic [CoordW-1:0] r,
                                                   logic [CoordW-1:0] c,
                                                   logic [ValueW-1:0] v);
    coef_result_t res;
    int slot;
    int k;
    res = '{value: '0, found: 1'b0, status: StDone};
    slot = -1;
    for (k = 0; k < used_entries; k++) begin
      if (slot < 0 && row_tab[k] == r && col_tab[k] == c) slot = k;
    end
    if (kind == ReqRead) begin
      if (slot >= 0) begin
        res.value = val_tab[slot];
        res.found = 1'b1;
      end
    end else if ({1'b0, r} >= row_limit || {1'b0, c} >= column_limit) begin
      res.status = StRange;
    end else if (v[ValueW-2:0] == '0) begin
      res.status = StZero;
    end else if (slot >= 0) begin
      val_tab[slot] = v;
      res.found = 1'b1;
    end else if (used_entries == Capacity) begin
      res.status = StFull;
    end else begin
      row_tab[used_entries] = r;
      col_tab[used_entries] = c;
      val_tab[used_entries] = v;
      used_entries++;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    coef_result_t want;
    if (!rst_ni) begin
      used_entries = 0;
      row_limit = SizeReset;
      column_limit = SizeReset;
      expected_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgRowCount) row_limit = cfg_wdata_i;
        else column_limit = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.insert(expected_results.size(),
                                resolve_request(req_type_i, row_index_i,
                                                column_index_i, write_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no request pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (read_value_i !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, read_value_i);
            mismatches++;
          end
          if (found_i !== want.found) begin
            $error("found: expected %b, got %b", want.found, found_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatches++;
          end
        end
      end
      outstanding_o <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### verif/sparse_coordinate_table_tb.sv
// Testbench top for sparse_coordinate_table: drives requests, size writes and
// output stalls, and gives the verdict from the count reported by sct_checker.
// Depends on sct_pkg, sct_tb_pkg, sct_checker and the block itself.
module sparse_coordinate_table_tb;
  import sct_pkg::*;
  import sct_tb_pkg::*;

  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 80;
  localparam int LongHold     = 400;
  localparam int PhaseItems   = 310;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = CfgRowCount;
  logic [SizeW-1:0]    cfg_wdata    = SizeReset;
  logic                in_valid     = 1'b0;
  logic                req_type     = ReqWrite;
  logic [CoordW-1:0]   row_index    = '0;
  logic [CoordW-1:0]   column_index = '0;
  logic [ValueW-1:0]   write_value  = '0;
  logic                out_stall    = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [ValueW-1:0]   read_value;
  logic                found;
  logic [StatusW-1:0]  status;
  int                  fail_count;
  int                  outstanding;
  int                  idle_cycles  = 0;
  int                  gap_odds     = 0;
  bit                  quiet        = 1'b0;
  bit                  hold_req     = 1'b0;

  always #1 clk = ~clk;

  sparse_coordinate_table i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .row_index_i    (row_index),
    .column_index_i (column_index),
    .write_value_i  (write_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_value_o   (read_value),
    .found_o        (found),
    .status_o       (status)
  );

  sct_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .row_index_i    (row_index),
    .column_index_i (column_index),
    .write_value_i  (write_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .read_value_i   (read_value),
    .found_i        (found),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (quiet) begin
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(16, 1)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 1)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic kind, input logic [CoordW-1:0] r,
                              input logic [CoordW-1:0] c, input logic [ValueW-1:0] v);
    if (!quiet && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    row_index    <= r;
    column_index <= c;
    write_value  <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_matrix_size(input logic [SizeW-1:0] rows, input logic [SizeW-1:0] cols);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CfgRowCount;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= CfgColumnCount;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a small coordinate pool so hits, overwrites and a full table occur;
  // the rest uses full-width coordinates.
  task automatic send_random();
    logic              kind;
    logic [CoordW-1:0] r;
    logic [CoordW-1:0] c;
    logic [ValueW-1:0] v;
    v = $urandom;
    if ($urandom_range(6, 0) == 0) begin
      kind = $urandom_range(1, 0) ? ReqRead : ReqWrite;
      r = CoordW'($urandom);
      c = CoordW'($urandom);
    end else begin
      kind = ($urandom_range(99, 0) < 45) ? ReqRead : ReqWrite;
      r = CoordW'($urandom_range(6, 0));
      c = CoordW'($urandom_range(9, 0));
      if ($urandom_range(9, 0) == 0) v[ValueW-2:0] = '0;
    end
    send_request(kind, r, c, v);
  endtask

  task automatic run_phase(input logic [SizeW-1:0] rows, input logic [SizeW-1:0] cols,
                           input int odds, input bit hold, input bit closing);
    set_matrix_size(rows, cols);
    gap_odds = odds;
    if (hold) hold_req = 1'b1;
    for (int n = 0; n < PhaseItems; n++) begin
      if (closing && n == PhaseItems - 150) quiet = 1'b1;
      send_random();
    end
  endtask

  initial begin : stimulus
    wait (rst_n);
    @(posedge clk);
    set_matrix_size(SizeReset, SizeReset);

    send_request(ReqRead,  16'h0000, 16'h0000, 32'h0000_0000);
    send_request(ReqWrite, 16'h0000, 16'h0000, 32'h3F80_0000);
    send_request(ReqRead,  16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_request(ReqWrite, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_request(ReqWrite, 16'h0000, 16'h0000, 32'h0000_0000);
    send_request(ReqWrite, 16'h0000, 16'h0000, 32'h8000_0000);
    send_request(ReqRead,  16'h0000, 16'h0000, 32'h0000_0000);
    send_request(ReqWrite, 16'hFFFF, 16'hFFFF, 32'h7FC0_0000);
    send_request(ReqWrite, 16'hFFFF, 16'h0000, 32'h0000_0001);
    send_request(ReqWrite, 16'h0000, 16'hFFFF, 32'h8000_0001);
    send_request(ReqRead,  16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_request(ReqRead,  16'hFFFF, 16'h0000, 32'h0000_0000);

    // shrunken matrix: range check precedes the zero test, old entries stay readable
    set_matrix_size(17'd2, 17'd3);
    send_request(ReqWrite, 16'h0002, 16'h0000, 32'h0000_0001);
    send_request(ReqWrite, 16'h0000, 16'h0003, 32'h0000_0001);
    send_request(ReqWrite, 16'h0002, 16'h0003, 32'h0000_0000);
    send_request(ReqWrite, 16'h0001, 16'h0002, 32'h4000_0000);
    send_request(ReqRead,  16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_request(ReqRead,  16'h0005, 16'h0005, 32'h0000_0000);

    set_matrix_size(17'd0, 17'd0);
    send_request(ReqWrite, 16'h0000, 16'h0000, 32'h3F80_0000);
    send_request(ReqRead,  16'h0001, 16'h0002, 32'h0000_0000);

    run_phase(SizeReset, SizeReset, 0, 1'b1, 1'b0);
    run_phase(17'h1FFFF, 17'h1FFFF, 4, 1'b0, 1'b0);
    run_phase(17'd8, 17'd8, 12, 1'b0, 1'b0);
    run_phase(17'd65535, 17'd65535, 0, 1'b0, 1'b0);
    run_phase(17'd0, 17'd0, 4, 1'b0, 1'b0);
    run_phase(17'd5, 17'd12, 12, 1'b0, 1'b1);

    wait_idle();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
